@@ rtl/core/qrs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qrs_pkg;

    localparam int CW    = 16;
    localparam int FB    = 16;
    localparam int OW    = 40;
    localparam int PW    = 2 * CW;
    localparam int DW    = 2 * CW + 1;
    localparam int SQW   = (DW + 2 * FB + 1) / 2;
    localparam int RADW  = 2 * SQW;
    localparam int REMW  = SQW + 2;
    localparam int NW    = (((CW - 1 + FB) > SQW) ? (CW - 1 + FB) : SQW) + 1;
    localparam int NSW   = NW + 1;
    localparam int DENSW = CW + 2;
    localparam int DMW   = CW + 1;
    localparam int XW    = ((NW > OW) ? NW : OW) + 1;
    localparam int QDEPTH = 2;
    localparam int QAW   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW   = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        OC_INDET   = 3'd0,
        OC_IMPOSS  = 3'd1,
        OC_LINEAR  = 3'd2,
        OC_TWO     = 3'd3,
        OC_DOUBLE  = 3'd4,
        OC_COMPLEX = 3'd5
    } outcome_t;

    typedef struct packed {
        logic signed [CW-1:0] coef_a;
        logic signed [CW-1:0] coef_b;
        logic signed [CW-1:0] coef_c;
    } in_word_t;

    typedef struct packed {
        outcome_t             outcome;
        logic signed [OW-1:0] first_value;
        logic signed [OW-1:0] second_value;
    } out_word_t;

    // classified equation handed from front to back
    typedef struct packed {
        outcome_t                outcome;
        logic [DW-1:0]           dmag;
        logic signed [NSW-1:0]   nbase;
        logic signed [DENSW-1:0] den;
    } qword_t;

endpackage

`default_nettype wire

@@ rtl/core/qrs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qrs_front
    import qrs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     coef_valid,
    output logic          coef_ready,
    input  wire in_word_t coef,
    output logic          push_valid,
    input  wire logic     push_ready,
    output qword_t        push_word
);

    typedef struct packed {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        logic [PW-1:0]        bb;
        logic [PW-1:0]        ac;
        logic                 ac_neg;
    } f1_t;

    logic   adv;
    logic   s1_vld_reg;
    logic   s2_vld_reg;
    f1_t    s1_reg;
    f1_t    s1_next;
    qword_t s2_reg;
    qword_t s2_next;

    logic [CW-1:0] ma;
    logic [CW-1:0] mb;
    logic [CW-1:0] mc;
    logic [DW-1:0] bbx;
    logic [DW-1:0] ac4;

    assign adv        = !s2_vld_reg || push_ready;
    assign coef_ready = adv;
    assign push_valid = s2_vld_reg;
    assign push_word  = s2_reg;

    always_comb
    begin
        ma = coef.coef_a[CW-1] ? CW'(-coef.coef_a) : CW'(coef.coef_a);
        mb = coef.coef_b[CW-1] ? CW'(-coef.coef_b) : CW'(coef.coef_b);
        mc = coef.coef_c[CW-1] ? CW'(-coef.coef_c) : CW'(coef.coef_c);
        s1_next.a      = coef.coef_a;
        s1_next.b      = coef.coef_b;
        s1_next.c      = coef.coef_c;
        s1_next.bb     = PW'(mb) * PW'(mb);
        s1_next.ac     = PW'(ma) * PW'(mc);
        s1_next.ac_neg = coef.coef_a[CW-1] != coef.coef_c[CW-1];
    end

    always_comb
    begin
        bbx = DW'(s1_reg.bb);
        ac4 = DW'({s1_reg.ac, 2'b00});
        s2_next.dmag  = '0;
        s2_next.nbase = -(NSW'(s1_reg.b) <<< FB);
        s2_next.den   = DENSW'(s1_reg.a) <<< 1;
        if (s1_reg.a == '0)
        begin
            s2_next.den   = DENSW'(s1_reg.b);
            s2_next.nbase = -(NSW'(s1_reg.c) <<< FB);
            if (s1_reg.b != '0)
                s2_next.outcome = OC_LINEAR;
            else if (s1_reg.c == '0)
                s2_next.outcome = OC_INDET;
            else
                s2_next.outcome = OC_IMPOSS;
        end
        else if (s1_reg.ac_neg)
        begin
            s2_next.dmag    = bbx + ac4;
            s2_next.outcome = (s2_next.dmag == '0) ? OC_DOUBLE : OC_TWO;
        end
        else if (bbx > ac4)
        begin
            s2_next.dmag    = bbx - ac4;
            s2_next.outcome = OC_TWO;
        end
        else if (bbx == ac4)
        begin
            s2_next.outcome = OC_DOUBLE;
        end
        else
        begin
            s2_next.dmag    = ac4 - bbx;
            s2_next.outcome = OC_COMPLEX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= coef_valid;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/qrs_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qrs_fifo
    import qrs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push_valid,
    output logic        push_ready,
    input  wire qword_t push_word,
    output logic        pop_valid,
    input  wire logic   pop_ready,
    output qword_t      pop_word
);

    qword_t         mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg;
    logic           do_push;
    logic           do_pop;

    assign push_ready = count_reg != QCW'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_word   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
        return (p == QAW'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_word;
    end

endmodule

`default_nettype wire

@@ rtl/core/qrs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module qrs_back
    import qrs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   head_valid,
    output logic        head_ready,
    input  wire qword_t head_word,
    output logic        root_valid,
    input  wire logic   root_ready,
    output out_word_t   root
);

    typedef struct packed {
        outcome_t                outcome;
        logic signed [NSW-1:0]   nbase;
        logic signed [DENSW-1:0] den;
        logic [RADW-1:0]         rad;
        logic [REMW-1:0]         rem;
        logic [SQW-1:0]          root;
    } sq_t;

    typedef struct packed {
        outcome_t       outcome;
        logic           neg1;
        logic           neg2;
        logic           dzero;
        logic [DMW-1:0] dmag;
        logic [DMW-1:0] r1;
        logic [NW-1:0]  x1;
        logic [DMW-1:0] r2;
        logic [NW-1:0]  x2;
    } dv_t;

    logic            adv;
    logic [SQW-1:0]  sq_vld_reg;
    logic            prep_vld_reg;
    logic [NW-1:0]   dv_vld_reg;
    logic            root_vld_reg;
    sq_t             sq_reg  [SQW];
    sq_t             sq_next [SQW];
    dv_t             prep_reg;
    dv_t             prep_next;
    dv_t             dv_reg  [NW];
    dv_t             dv_next [NW];
    out_word_t       root_reg;
    out_word_t       root_next;
    sq_t             sq_head;
    logic signed [NSW-1:0] sx;
    logic signed [NSW-1:0] n1;
    logic signed [NSW-1:0] n2;
    sq_t             sq_last;
    dv_t             dv_last;

    assign adv        = !root_vld_reg || root_ready;
    assign head_ready = adv;
    assign root_valid = root_vld_reg;
    assign root       = root_reg;

    function automatic sq_t sq_step(input sq_t s);
        sq_t             r;
        logic [REMW-1:0] t;
        logic [REMW-1:0] trial;
        r       = s;
        t       = {s.rem[REMW-3:0], s.rad[RADW-1 -: 2]};
        trial   = {s.root, 2'b01};
        r.rad   = {s.rad[RADW-3:0], 2'b00};
        if (t >= trial)
        begin
            r.rem  = t - trial;
            r.root = {s.root[SQW-2:0], 1'b1};
        end
        else
        begin
            r.rem  = t;
            r.root = {s.root[SQW-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic void dv_bit(
        input  logic [DMW-1:0] d,
        input  logic [DMW-1:0] r_in,
        input  logic [NW-1:0]  x_in,
        output logic [DMW-1:0] r_out,
        output logic [NW-1:0]  x_out
    );
        logic [DMW:0] t;
        logic         ge;
        t     = {r_in, x_in[NW-1]};
        ge    = t >= {1'b0, d};
        t     = ge ? t - {1'b0, d} : t;
        r_out = t[DMW-1:0];
        x_out = {x_in[NW-2:0], ge};
    endfunction

    function automatic dv_t dv_step(input dv_t s);
        dv_t            r;
        logic [DMW-1:0] ra;
        logic [NW-1:0]  xa;
        logic [DMW-1:0] rb;
        logic [NW-1:0]  xb;
        r = s;
        dv_bit(s.dmag, s.r1, s.x1, ra, xa);
        dv_bit(s.dmag, s.r2, s.x2, rb, xb);
        r.r1 = ra;
        r.x1 = xa;
        r.r2 = rb;
        r.x2 = xb;
        return r;
    endfunction

    function automatic logic [NW-1:0] mag_n(input logic signed [NSW-1:0] v);
        return v[NSW-1] ? NW'(-v) : NW'(v);
    endfunction

    function automatic logic [OW-1:0] finish(
        input logic [NW-1:0] q,
        input logic          neg,
        input logic          dzero
    );
        logic [XW-1:0] qx;
        logic [XW-1:0] lim;
        logic [XW-1:0] v;
        qx  = XW'(q);
        lim = XW'(1) << (OW - 1);
        if (dzero)
            v = '0;
        else if (qx >= lim)
            v = neg ? -lim : lim - 1'b1;
        else
            v = neg ? -qx : qx;
        return v[OW-1:0];
    endfunction

    // square root: one result bit per stage
    always_comb
    begin
        sq_head.outcome = head_word.outcome;
        sq_head.nbase   = head_word.nbase;
        sq_head.den     = head_word.den;
        sq_head.rad     = RADW'(head_word.dmag) << (2 * FB);
        sq_head.rem     = '0;
        sq_head.root    = '0;
        for (int i = 0; i < SQW; i++)
            sq_next[i] = sq_step((i == 0) ? sq_head : sq_reg[(i == 0) ? 0 : i - 1]);
    end

    // numerators and divisor in sign/magnitude form
    always_comb
    begin
        sq_last = sq_reg[SQW-1];
        sx      = NSW'(sq_last.root);
        case (sq_last.outcome)
            OC_TWO:
            begin
                n1 = sq_last.nbase + sx;
                n2 = sq_last.nbase - sx;
            end
            OC_DOUBLE:
            begin
                n1 = sq_last.nbase;
                n2 = sq_last.nbase;
            end
            OC_COMPLEX:
            begin
                n1 = sq_last.nbase;
                n2 = sx;
            end
            OC_LINEAR:
            begin
                n1 = sq_last.nbase;
                n2 = '0;
            end
            default:
            begin
                n1 = '0;
                n2 = '0;
            end
        endcase
        prep_next.outcome = sq_last.outcome;
        prep_next.dzero   = sq_last.den == '0;
        prep_next.dmag    = sq_last.den[DENSW-1] ? DMW'(-sq_last.den) : DMW'(sq_last.den);
        prep_next.neg1    = n1[NSW-1] != sq_last.den[DENSW-1];
        prep_next.neg2    = n2[NSW-1] != sq_last.den[DENSW-1];
        prep_next.r1      = '0;
        prep_next.x1      = mag_n(n1);
        prep_next.r2      = '0;
        prep_next.x2      = mag_n(n2);
    end

    // divider: one quotient bit per stage, both roots side by side
    always_comb
    begin
        for (int j = 0; j < NW; j++)
            dv_next[j] = dv_step((j == 0) ? prep_reg : dv_reg[(j == 0) ? 0 : j - 1]);
    end

    always_comb
    begin
        dv_last                = dv_reg[NW-1];
        root_next.outcome      = dv_last.outcome;
        root_next.first_value  = finish(dv_last.x1, dv_last.neg1, dv_last.dzero);
        root_next.second_value = finish(dv_last.x2, dv_last.neg2, dv_last.dzero);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg   <= '0;
            prep_vld_reg <= 1'b0;
            dv_vld_reg   <= '0;
            root_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            sq_vld_reg   <= {sq_vld_reg[SQW-2:0], head_valid};
            prep_vld_reg <= sq_vld_reg[SQW-1];
            dv_vld_reg   <= {dv_vld_reg[NW-2:0], prep_vld_reg};
            root_vld_reg <= dv_vld_reg[NW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < SQW; i++)
                sq_reg[i] <= sq_next[i];
            prep_reg <= prep_next;
            for (int j = 0; j < NW; j++)
                dv_reg[j] <= dv_next[j];
            root_reg <= root_next;
        end
    end

    a_no_roots_zero: assert property (@(posedge clk) disable iff (!rst_n)
        root_vld_reg && (root_reg.outcome == OC_INDET || root_reg.outcome == OC_IMPOSS)
        |-> root_reg.first_value == '0 && root_reg.second_value == '0)
        else $error("no-root outcome with nonzero values");

    a_double_equal: assert property (@(posedge clk) disable iff (!rst_n)
        root_vld_reg && root_reg.outcome == OC_DOUBLE
        |-> root_reg.first_value == root_reg.second_value)
        else $error("double root values differ");

    a_linear_second: assert property (@(posedge clk) disable iff (!rst_n)
        root_vld_reg && root_reg.outcome == OC_LINEAR |-> root_reg.second_value == '0)
        else $error("linear outcome with nonzero second value");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(dv_vld_reg) && $stable(sq_vld_reg))
        else $error("pipeline moved while stalled");

endmodule

`default_nettype wire

@@ rtl/core/quadratic_root_solver.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Quadratic root solver for a*x^2 + b*x + c = 0 with signed integer coefficients.
// Input channel coef (coef_valid/coef_ready) carries one word with a, b, c.
// Output channel root (root_valid/root_ready) carries one word per input word:
// an outcome class and two signed values with 16 fractional bits.
// Throughput: one word per cycle with no gaps while root_ready stays high.
// Path from input acceptance to root_valid: 2 front stages (products, then
// discriminant and class), a 2-entry queue, a 33-stage square root at one
// result bit per stage, one numerator stage, a 34-stage divider at one
// quotient bit per stage, and the output register.
// The front and the back stall independently; the queue absorbs the slip.
// When root_ready is low with a word waiting, the back pipeline holds, the
// queue fills, and then coef_ready drops. Nothing is lost or repeated.
// Reset (rst_n low) empties every stage and the queue; no result is pending
// afterwards and coef_ready is high, so words are taken once reset is released.
module quadratic_root_solver
    import qrs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      coef_valid,
    output logic           coef_ready,
    input  wire in_word_t  coef,
    output logic           root_valid,
    input  wire logic      root_ready,
    output out_word_t      root
);

    logic   push_valid;
    logic   push_ready;
    qword_t push_word;
    logic   pop_valid;
    logic   pop_ready;
    qword_t pop_word;

    qrs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_valid (coef_valid),
        .coef_ready (coef_ready),
        .coef       (coef),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word)
    );

    qrs_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_word   (pop_word)
    );

    qrs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (pop_valid),
        .head_ready (pop_ready),
        .head_word  (pop_word),
        .root_valid (root_valid),
        .root_ready (root_ready),
        .root       (root)
    );

endmodule

`default_nettype wire

@@ verif/root_checker.sv @@
`timescale 1ns / 1ps

module root_checker
    import qrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      coef_valid,
    input  logic      coef_ready,
    input  in_word_t  coef,
    input  logic      root_valid,
    input  logic      root_ready,
    input  out_word_t root,
    output int        fail_count,
    output int        pending
);

    localparam longint OUT_MAX = (64'sd1 <<< 39) - 1;
    localparam longint OUT_MIN = -(64'sd1 <<< 39);

    out_word_t expected_roots[$];

    function automatic longint trunc_div_sat(longint num, longint den);
        longint q;
        if (den == 0)
            return 0;
        q = num / den;
        if (q > OUT_MAX)
            return OUT_MAX;
        if (q < OUT_MIN)
            return OUT_MIN;
        return q;
    endfunction

    // floor(sqrt(x)) on 128-bit magnitude
    function automatic longint isqrt_wide(logic [127:0] x);
        logic [127:0] r;
        logic [127:0] cand;
        r = 0;
        for (int bitpos = 63; bitpos >= 0; bitpos--)
        begin
            cand = r | (128'd1 << bitpos);
            if (cand * cand <= x)
                r = cand;
        end
        return longint'(r[63:0]);
    endfunction

    function automatic out_word_t solve_roots(in_word_t w);
        out_word_t r;
        longint a;
        longint b;
        longint c;
        longint disc;
        longint s;
        longint nb;
        longint v1;
        longint v2;
        a = longint'(w.coef_a);
        b = longint'(w.coef_b);
        c = longint'(w.coef_c);
        v1 = 0;
        v2 = 0;
        nb = -b * (64'sd1 <<< FB);
        if (a == 0)
        begin
            if (b == 0)
                r.outcome = (c == 0) ? OC_INDET : OC_IMPOSS;
            else
            begin
                r.outcome = OC_LINEAR;
                v1 = trunc_div_sat(-c * (64'sd1 <<< FB), b);
            end
        end
        else
        begin
            disc = b * b - 4 * a * c;
            if (disc == 0)
            begin
                r.outcome = OC_DOUBLE;
                v1 = trunc_div_sat(nb, 2 * a);
                v2 = v1;
            end
            else
            begin
                s = isqrt_wide(128'((disc < 0) ? -disc : disc) << (2 * FB));
                if (disc > 0)
                begin
                    r.outcome = OC_TWO;
                    v1 = trunc_div_sat(nb + s, 2 * a);
                    v2 = trunc_div_sat(nb - s, 2 * a);
                end
                else
                begin
                    r.outcome = OC_COMPLEX;
                    v1 = trunc_div_sat(nb, 2 * a);
                    v2 = trunc_div_sat(s, 2 * a);
                end
            end
        end
        r.first_value = v1[OW-1:0];
        r.second_value = v2[OW-1:0];
        return r;
    endfunction

    assign pending = expected_roots.size();

    initial fail_count = 0;

    always @(posedge clk)
    begin
        out_word_t want;
        int errs;
        errs = 0;
        if (rst_n)
        begin
            if (coef_valid && coef_ready)
                expected_roots.push_back(solve_roots(coef));
            if (root_valid && root_ready)
            begin
                if (expected_roots.size() == 0)
                begin
                    $error("unexpected root word %h", root);
                    errs++;
                end
                else
                begin
                    want = expected_roots.pop_front();
                    if (root.outcome !== want.outcome)
                    begin
                        $error("outcome: expected %0d actual %0d", want.outcome, root.outcome);
                        errs++;
                    end
                    if (root.first_value !== want.first_value)
                    begin
                        $error("first_value: expected %0d actual %0d",
                               want.first_value, root.first_value);
                        errs++;
                    end
                    if (root.second_value !== want.second_value)
                    begin
                        $error("second_value: expected %0d actual %0d",
                               want.second_value, root.second_value);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import qrs_pkg::*;

    localparam int RANDOM_WORDS = 1630;
    localparam int STALL_LIMIT = 2000;

    logic      clk;
    logic      rst_n;
    logic      coef_valid;
    logic      coef_ready;
    in_word_t  coef;
    logic      root_valid;
    logic      root_ready;
    out_word_t root;
    int        fail_count;
    int        pending;
    int        idle_cycles;
    bit        quiet_phase;
    bit        hold_off;
    bit        stim_done;

    quadratic_root_solver DUT (
        .clk(clk), .rst_n(rst_n),
        .coef_valid(coef_valid), .coef_ready(coef_ready), .coef(coef),
        .root_valid(root_valid), .root_ready(root_ready), .root(root)
    );

    root_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .coef_valid(coef_valid), .coef_ready(coef_ready), .coef(coef),
        .root_valid(root_valid), .root_ready(root_ready), .root(root),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3, 4: return 16'($signed($urandom_range(0, 40)) - 20);
            5: return 16'($signed($urandom_range(0, 600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    // some equations come from chosen roots so double and two-root cases are frequent
    function automatic in_word_t pick_equation();
        in_word_t w;
        logic signed [15:0] p;
        logic signed [15:0] q;
        logic signed [15:0] k;
        w.coef_a = pick_coef();
        w.coef_b = pick_coef();
        w.coef_c = pick_coef();
        case ($urandom_range(0, 9))
            0: w.coef_a = 0;
            1:
            begin
                w.coef_a = 0;
                w.coef_b = 0;
            end
            2, 3:
            begin
                k = 16'($signed($urandom_range(0, 20)) - 10);
                p = 16'($signed($urandom_range(0, 40)) - 20);
                q = ($urandom_range(0, 1)) ? p : 16'($signed($urandom_range(0, 40)) - 20);
                if (k == 0)
                    k = 1;
                w.coef_a = k;
                w.coef_b = -k * (p + q);
                w.coef_c = k * p * q;
            end
            default: ;
        endcase
        return w;
    endfunction

    // leaves valid high at the next falling edge; each pause, here or in the caller, drops it
    task automatic send_word(in_word_t w);
        while (!quiet_phase && $urandom_range(0, 99) < 9)
        begin
            coef_valid <= 1'b0;
            @(negedge clk);
        end
        coef <= w;
        coef_valid <= 1'b1;
        @(posedge clk);
        while (!coef_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_directed();
        logic [15:0] edge_vals[4];
        in_word_t w;
        edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        w = '{16'd0, 16'd0, 16'd0};     send_word(w);
        w = '{16'd0, 16'd0, 16'd5};     send_word(w);
        w = '{16'd0, 16'd3, 16'd7};     send_word(w);
        w = '{16'd0, 16'hffff, 16'h8000}; send_word(w);
        w = '{16'd1, 16'hfffd, 16'd2};  send_word(w);
        w = '{16'd1, 16'd2, 16'd1};     send_word(w);
        w = '{16'd1, 16'd0, 16'd1};     send_word(w);
        w = '{16'hffff, 16'd0, 16'hffff}; send_word(w);
        w = '{16'hffff, 16'd2, 16'd5};  send_word(w);
        for (int i = 0; i < 16; i++)
        begin
            w.coef_a = edge_vals[i % 4];
            w.coef_b = edge_vals[(i / 4) % 4];
            w.coef_c = edge_vals[(i + 1) % 4];
            send_word(w);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        coef_valid = 1'b0;
        coef = '0;
        quiet_phase = 1'b0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_directed();
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            quiet_phase = (i >= 300 && i < 500);
            if (i == 700)
                hold_off = 1'b1;
            if (i == 1000)
            begin
                coef_valid <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            send_word(pick_equation());
        end
        coef_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        stim_done = 1'b1;
    end

    initial
    begin
        root_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                root_ready <= 1'b0;
                repeat (200) @(negedge clk);
                hold_off = 1'b0;
            end
            root_ready <= quiet_phase || ($urandom_range(0, 99) >= 9);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (coef_valid && coef_ready) || (root_valid && root_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (stim_done)
            begin
                if (fail_count == 0 && pending == 0)
                    $display("[ OK ] regression clean");
                else
                    $display("[FAIL] regression broken");
                $finish;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
